FILE: src/q2e_pkg.sv
// Package for the quaternion to Euler angle converter.
// Holds CORDIC constants, case codes and a shared helper function; no dependencies.
`default_nettype none
package q2e_pkg;

    localparam int CordicSteps = 28;
    localparam int CordicWidth = 46;

    typedef logic signed [CordicWidth-1:0] cword_t;
    typedef logic signed [34:0] angle_t;

    typedef enum logic [1:0] {
        KIND_REGULAR = 2'd0,
        KIND_NORTH   = 2'd1,
        KIND_SOUTH   = 2'd2,
        KIND_ZERO    = 2'd3
    } kind_t;

    localparam angle_t Q30_PI      = 35'sd3373259426;
    localparam angle_t Q30_HALF_PI = 35'sd1686629713;

    function automatic angle_t atan_entry(input int unsigned idx);
        logic [31:0] v;
        begin
            case (idx)
                0: v = 32'h3243F6A8;
                1: v = 32'h1DAC6705;
                2: v = 32'h0FADBAFC;
                3: v = 32'h07F56EA6;
                4: v = 32'h03FEAB76;
                5: v = 32'h01FFD55B;
                6: v = 32'h00FFFAAA;
                7: v = 32'h007FFF55;
                8: v = 32'h003FFFEA;
                9: v = 32'h001FFFFD;
                default: v = (32'h00100000 >> (idx - 10)) - 32'd1;
            endcase
            atan_entry = angle_t'({3'b000, v});
        end
    endfunction

endpackage
`default_nettype wire

FILE: src/quaternion_to_euler.sv
// Top level of the quaternion to Euler angle converter.
// Depends on q2e_pkg and q2e_cordic.
//
// Usage: drive quat_x/y/z/w and pulse start; busy is always low, so a word is
// taken in every cycle in which start is high. Each accepted word yields one
// result word on angle_first, angle_second, angle_third and case_kind, marked
// by a one-cycle done strobe, in input order.
// The pipeline has 64 register stages: input scaling; products, sums and
// pole tests; normalize; the first CORDIC bank; forming the asin operands;
// the second CORDIC bank; and the output register. The two 28-step CORDIC
// pipelines make up most of the depth; throughput is one word per cycle. The
// thr_reg pole threshold register is written through cfg_valid/cfg_ready
// (always ready) and resets to 499. Reset clears all valid bits, so nothing
// in flight survives it. The receiver cannot stall, so there is no
// backpressure anywhere in the pipeline.
`default_nettype none
module quaternion_to_euler
#(
    parameter int ANGLE_FRAC_BITS = 13,
    parameter int IN_WIDTH        = 16
)
(
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         start,
    output logic                        busy,
    input  wire  signed [IN_WIDTH-1:0]  quat_x,
    input  wire  signed [IN_WIDTH-1:0]  quat_y,
    input  wire  signed [IN_WIDTH-1:0]  quat_z,
    input  wire  signed [IN_WIDTH-1:0]  quat_w,
    input  wire                         cfg_valid,
    output logic                        cfg_ready,
    input  wire  [8:0]                  cfg_data,
    output logic                        done,
    output logic signed [15:0]          angle_first,
    output logic signed [15:0]          angle_second,
    output logic signed [14:0]          angle_third,
    output logic [1:0]                  case_kind
);

    localparam int SH = 30 - ANGLE_FRAC_BITS;
    localparam int MW = IN_WIDTH + 1;
    localparam int NC = q2e_pkg::CordicSteps;

    typedef logic signed [16:0] comp_t;   // components after scaling, |v| <= 2^15
    typedef logic signed [17:0] sum_t;    // sums and differences of two components
    typedef logic signed [35:0] prod_t;
    typedef logic signed [47:0] big_t;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    logic [8:0] thr_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= 9'd499;
        else if (cfg_valid)
            thr_reg <= cfg_data;
    end

    // ---------------- stage 1: magnitude scaling ----------------
    logic [MW-1:0] mg [4];
    logic          ng [4];
    logic [MW-1:0] mx;
    logic [5:0]    shamt;
    comp_t         sc [4];

    always_comb
    begin
        mg[0] = MW'(quat_x[IN_WIDTH-1] ? -$signed({quat_x[IN_WIDTH-1], quat_x})
                                        : $signed({1'b0, quat_x}));
        mg[1] = MW'(quat_y[IN_WIDTH-1] ? -$signed({quat_y[IN_WIDTH-1], quat_y})
                                        : $signed({1'b0, quat_y}));
        mg[2] = MW'(quat_z[IN_WIDTH-1] ? -$signed({quat_z[IN_WIDTH-1], quat_z})
                                        : $signed({1'b0, quat_z}));
        mg[3] = MW'(quat_w[IN_WIDTH-1] ? -$signed({quat_w[IN_WIDTH-1], quat_w})
                                        : $signed({1'b0, quat_w}));
        ng[0] = quat_x[IN_WIDTH-1];
        ng[1] = quat_y[IN_WIDTH-1];
        ng[2] = quat_z[IN_WIDTH-1];
        ng[3] = quat_w[IN_WIDTH-1];
        mx = mg[0];
        for (int k = 1; k < 4; k++)
            if (mg[k] > mx)
                mx = mg[k];
        shamt = '0;
        for (int s = 1; s <= MW; s++)
            if ((34'(mx) >> (s - 1)) > 34'd32768)
                shamt = 6'(s);
        for (int k = 0; k < 4; k++)
        begin
            sc[k] = comp_t'($signed({1'b0, 17'(mg[k] >> shamt)}));
            if (ng[k])
                sc[k] = -sc[k];
        end
    end

    logic  v1_reg;
    comp_t x1_reg, y1_reg, z1_reg, w1_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= start;
    end
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x1_reg <= sc[0];
            y1_reg <= sc[1];
            z1_reg <= sc[2];
            w1_reg <= sc[3];
        end
    end

    // ---------------- stage 2: squares, cross products and component sums ----------------
    logic  v2_reg;
    comp_t x2_reg, w2_reg;
    prod_t xx_reg, yy_reg, zz_reg, ww_reg, xy_reg, zw_reg, xw_reg, yz_reg, yw_reg, xz_reg;
    sum_t  sa_reg, sb_reg, sc_reg, sd_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v1_reg;
    end
    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            x2_reg <= x1_reg;
            w2_reg <= w1_reg;
            xx_reg <= prod_t'(x1_reg * x1_reg);
            yy_reg <= prod_t'(y1_reg * y1_reg);
            zz_reg <= prod_t'(z1_reg * z1_reg);
            ww_reg <= prod_t'(w1_reg * w1_reg);
            xy_reg <= prod_t'(x1_reg * y1_reg);
            zw_reg <= prod_t'(z1_reg * w1_reg);
            xw_reg <= prod_t'(x1_reg * w1_reg);
            yz_reg <= prod_t'(y1_reg * z1_reg);
            yw_reg <= prod_t'(y1_reg * w1_reg);
            xz_reg <= prod_t'(x1_reg * z1_reg);
            sa_reg <= sum_t'(x1_reg) - sum_t'(y1_reg);
            sb_reg <= sum_t'(z1_reg) - sum_t'(w1_reg);
            sc_reg <= sum_t'(x1_reg) + sum_t'(y1_reg);
            sd_reg <= sum_t'(z1_reg) + sum_t'(w1_reg);
        end
    end

    // ---------------- stage 3: sums ----------------
    logic  v3_reg;
    comp_t x3_reg, w3_reg;
    prod_t len3_reg, test3_reg, fy3_reg, fx3_reg, sy3_reg, sx3_reg;
    sum_t  sa3_reg, sb3_reg, sc3_reg, sd3_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else
            v3_reg <= v2_reg;
    end
    always_ff @(posedge clk)
    begin
        if (v2_reg)
        begin
            x3_reg    <= x2_reg;
            w3_reg    <= w2_reg;
            len3_reg  <= xx_reg + yy_reg + zz_reg + ww_reg;
            test3_reg <= xy_reg + zw_reg;
            fy3_reg   <= 2 * (xw_reg - yz_reg);
            fx3_reg   <= yy_reg + ww_reg - xx_reg - zz_reg;
            sy3_reg   <= 2 * (yw_reg - xz_reg);
            sx3_reg   <= xx_reg + ww_reg - yy_reg - zz_reg;
            sa3_reg   <= sa_reg;
            sb3_reg   <= sb_reg;
            sc3_reg   <= sc_reg;
            sd3_reg   <= sd_reg;
        end
    end

    // ---------------- stage 4: pole tests ----------------
    big_t t1000, lthr;
    assign t1000 = big_t'(test3_reg) * 48'sd1000;
    assign lthr  = big_t'(len3_reg) * $signed({39'd0, thr_reg});

    q2e_pkg::kind_t kind_c;
    always_comb
    begin
        if (len3_reg == '0)
            kind_c = q2e_pkg::KIND_ZERO;
        else if (t1000 > lthr)
            kind_c = q2e_pkg::KIND_NORTH;
        else if (t1000 < -lthr)
            kind_c = q2e_pkg::KIND_SOUTH;
        else
            kind_c = q2e_pkg::KIND_REGULAR;
    end

    logic  v4_reg;
    q2e_pkg::kind_t kind4_reg;
    prod_t ay4_reg [3];
    prod_t ax4_reg [3];
    sum_t  sa4_reg, sb4_reg, sc4_reg, sd4_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else
            v4_reg <= v3_reg;
    end
    always_ff @(posedge clk)
    begin
        if (v3_reg)
        begin
            kind4_reg  <= kind_c;
            ay4_reg[0] <= fy3_reg;
            ax4_reg[0] <= fx3_reg;
            ay4_reg[1] <= sy3_reg;
            ax4_reg[1] <= sx3_reg;
            ay4_reg[2] <= prod_t'(x3_reg);
            ax4_reg[2] <= prod_t'(w3_reg);
            sa4_reg <= sa3_reg;
            sb4_reg <= sb3_reg;
            sc4_reg <= sc3_reg;
            sd4_reg <= sd3_reg;
        end
    end

    // ---------------- stage 5: normalize and prefold ----------------
    // Operands are doubled until one magnitude reaches 2^40; the leading-one
    // position gives that count directly.
    function automatic q2e_pkg::cword_t norm_shift(input prod_t y, input prod_t x,
                                                   input prod_t v);
        logic [35:0] ay, ax, m;
        int          p;
        begin
            ay = y[35] ? 36'(-y) : 36'(y);
            ax = x[35] ? 36'(-x) : 36'(x);
            m  = ay | ax;
            p  = 0;
            for (int b = 0; b < 36; b++)
                if (m[b])
                    p = b;
            norm_shift = q2e_pkg::cword_t'(v) <<< (40 - p);
        end
    endfunction

    logic           v5_reg;
    q2e_pkg::kind_t kind5_reg;
    q2e_pkg::cword_t cx_reg [5];
    q2e_pkg::cword_t cy_reg [5];
    q2e_pkg::angle_t cz_reg [5];
    logic [2:0]      zr5_reg;

    // The magnitude of (x - y, z - w) takes x - y as its x operand, and the
    // magnitude of (x + y, z + w) takes x + y.
    q2e_pkg::cword_t nx [5];
    q2e_pkg::cword_t ny [5];
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            nx[k] = norm_shift(ay4_reg[k], ax4_reg[k], ax4_reg[k]);
            ny[k] = norm_shift(ay4_reg[k], ax4_reg[k], ay4_reg[k]);
        end
        nx[3] = q2e_pkg::cword_t'(sa4_reg) <<< 24;
        ny[3] = q2e_pkg::cword_t'(sb4_reg) <<< 24;
        nx[4] = q2e_pkg::cword_t'(sc4_reg) <<< 24;
        ny[4] = q2e_pkg::cword_t'(sd4_reg) <<< 24;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else
            v5_reg <= v4_reg;
    end
    always_ff @(posedge clk)
    begin
        if (v4_reg)
        begin
            kind5_reg <= kind4_reg;
            for (int k = 0; k < 3; k++)
                zr5_reg[k] <= (ay4_reg[k] == '0) && (ax4_reg[k] == '0);
            for (int k = 0; k < 5; k++)
            begin
                if (nx[k] < 0)
                begin
                    cx_reg[k] <= -nx[k];
                    cy_reg[k] <= -ny[k];
                    cz_reg[k] <= (ny[k] >= 0) ? q2e_pkg::Q30_PI : -q2e_pkg::Q30_PI;
                end
                else
                begin
                    cx_reg[k] <= nx[k];
                    cy_reg[k] <= ny[k];
                    cz_reg[k] <= '0;
                end
            end
        end
    end

    q2e_pkg::cword_t ca_x [5];
    q2e_pkg::cword_t ca_y [5];
    always_comb
    begin
        for (int k = 0; k < 5; k++)
        begin
            ca_x[k] = cx_reg[k];
            ca_y[k] = cy_reg[k];
        end
    end

    // ---------------- first CORDIC bank ----------------
    q2e_pkg::cword_t ox [5];
    q2e_pkg::angle_t oz [5];
    genvar g;
    generate
        for (g = 0; g < 5; g++)
        begin : g_bank1
            q2e_cordic u_cordic
            (
                .clk      (clk),
                .rst_n    (rst_n),
                .in_valid (v5_reg),
                .in_x     (ca_x[g]),
                .in_y     (ca_y[g]),
                .in_z     (cz_reg[g]),
                .out_x    (ox[g]),
                .out_z    (oz[g])
            );
        end
    endgenerate

    // Side pipeline carrying kind and zero flags through the first bank.
    logic [NC-1:0]  vd_reg;
    q2e_pkg::kind_t kd_reg [NC];
    logic [2:0]     zd_reg [NC];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vd_reg <= '0;
        else
            vd_reg <= {vd_reg[NC-2:0], v5_reg};
    end
    always_ff @(posedge clk)
    begin
        kd_reg[0] <= kind5_reg;
        zd_reg[0] <= zr5_reg;
        for (int k = 1; k < NC; k++)
        begin
            kd_reg[k] <= kd_reg[k-1];
            zd_reg[k] <= zd_reg[k-1];
        end
    end

    function automatic q2e_pkg::angle_t clamp_pi(input q2e_pkg::angle_t z);
        begin
            if (z > q2e_pkg::Q30_PI)
                clamp_pi = q2e_pkg::Q30_PI;
            else if (z < -q2e_pkg::Q30_PI)
                clamp_pi = -q2e_pkg::Q30_PI;
            else
                clamp_pi = z;
        end
    endfunction

    // ---------------- stage A: angles of bank one, magnitudes ----------------
    logic           va_reg;
    q2e_pkg::kind_t kinda_reg;
    q2e_pkg::angle_t a0_reg, a1_reg, a2_reg;
    q2e_pkg::cword_t ma_reg, mb_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            va_reg <= 1'b0;
        else
            va_reg <= vd_reg[NC-1];
    end
    always_ff @(posedge clk)
    begin
        if (vd_reg[NC-1])
        begin
            kinda_reg <= kd_reg[NC-1];
            a0_reg <= zd_reg[NC-1][0] ? '0 : clamp_pi(oz[0]);
            a1_reg <= zd_reg[NC-1][1] ? '0 : clamp_pi(oz[1]);
            a2_reg <= zd_reg[NC-1][2] ? '0 : clamp_pi(oz[2]);
            ma_reg <= ox[3];
            mb_reg <= ox[4];
        end
    end

    // ---------------- stage B: normalize asin operands ----------------
    logic           vb_reg;
    q2e_pkg::kind_t kindb_reg;
    q2e_pkg::angle_t b0_reg, b1_reg, b2_reg;
    q2e_pkg::cword_t bx_reg, by_reg;
    logic            bzr_reg;
    logic [45:0]     mm;
    int              mp;
    always_comb
    begin
        mm = 46'(ma_reg) | 46'(mb_reg);
        mp = 0;
        for (int b = 0; b < 46; b++)
            if (mm[b])
                mp = b;
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vb_reg <= 1'b0;
        else
            vb_reg <= va_reg;
    end
    always_ff @(posedge clk)
    begin
        if (va_reg)
        begin
            kindb_reg <= kinda_reg;
            b0_reg <= a0_reg;
            b1_reg <= a1_reg;
            b2_reg <= a2_reg;
            bzr_reg <= (ma_reg == '0) && (mb_reg == '0);
            if (mp < 40)
            begin
                bx_reg <= ma_reg <<< (40 - mp);
                by_reg <= mb_reg <<< (40 - mp);
            end
            else
            begin
                bx_reg <= ma_reg;
                by_reg <= mb_reg;
            end
        end
    end

    // ---------------- second CORDIC bank: asin via atan2(b, a) ----------------
    q2e_pkg::cword_t ox2;
    q2e_pkg::angle_t oz2;
    q2e_cordic u_cordic_asin
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (vb_reg),
        .in_x     (bx_reg),
        .in_y     (by_reg),
        .in_z     ('0),
        .out_x    (ox2),
        .out_z    (oz2)
    );

    logic [NC-1:0]   ve_reg;
    q2e_pkg::kind_t  ke_reg [NC];
    q2e_pkg::angle_t e0_reg [NC];
    q2e_pkg::angle_t e1_reg [NC];
    q2e_pkg::angle_t e2_reg [NC];
    logic [NC-1:0]   ez_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ve_reg <= '0;
        else
            ve_reg <= {ve_reg[NC-2:0], vb_reg};
    end
    always_ff @(posedge clk)
    begin
        ke_reg[0] <= kindb_reg;
        e0_reg[0] <= b0_reg;
        e1_reg[0] <= b1_reg;
        e2_reg[0] <= b2_reg;
        ez_reg[0] <= bzr_reg;
        for (int k = 1; k < NC; k++)
        begin
            ke_reg[k] <= ke_reg[k-1];
            e0_reg[k] <= e0_reg[k-1];
            e1_reg[k] <= e1_reg[k-1];
            e2_reg[k] <= e2_reg[k-1];
            ez_reg[k] <= ez_reg[k-1];
        end
    end

    // ---------------- stage F: select by case ----------------
    q2e_pkg::angle_t ta;
    logic signed [36:0] t3, d2;
    q2e_pkg::angle_t f_first, f_second, f_third;
    always_comb
    begin
        ta = ez_reg[NC-1] ? '0 : clamp_pi(oz2);
        t3 = 37'(ta) * 2 - 37'(q2e_pkg::Q30_HALF_PI);
        if (t3 > 37'(q2e_pkg::Q30_HALF_PI))
            t3 = 37'(q2e_pkg::Q30_HALF_PI);
        if (t3 < -37'(q2e_pkg::Q30_HALF_PI))
            t3 = -37'(q2e_pkg::Q30_HALF_PI);
        d2 = 37'(e2_reg[NC-1]) * 2;
        if (ke_reg[NC-1] == q2e_pkg::KIND_SOUTH)
            d2 = -d2;
        if (d2 > 37'(q2e_pkg::Q30_PI))
            d2 = d2 - 2 * 37'(q2e_pkg::Q30_PI);
        if (d2 < -37'(q2e_pkg::Q30_PI))
            d2 = d2 + 2 * 37'(q2e_pkg::Q30_PI);
        case (ke_reg[NC-1])
            q2e_pkg::KIND_REGULAR:
            begin
                f_first  = e0_reg[NC-1];
                f_second = e1_reg[NC-1];
                f_third  = q2e_pkg::angle_t'(t3);
            end
            q2e_pkg::KIND_NORTH:
            begin
                f_first  = '0;
                f_second = q2e_pkg::angle_t'(d2);
                f_third  = q2e_pkg::Q30_HALF_PI;
            end
            q2e_pkg::KIND_SOUTH:
            begin
                f_first  = '0;
                f_second = q2e_pkg::angle_t'(d2);
                f_third  = -q2e_pkg::Q30_HALF_PI;
            end
            default:
            begin
                f_first  = '0;
                f_second = '0;
                f_third  = '0;
            end
        endcase
    end

    function automatic logic [15:0] round_out(input q2e_pkg::angle_t q);
        q2e_pkg::angle_t r;
        begin
            r = (q + (q2e_pkg::angle_t'(1) <<< (SH - 1))) >>> SH;
            round_out = r[15:0];
        end
    endfunction

    logic [15:0] r0, r1, r2;
    assign r0 = round_out(f_first);
    assign r1 = round_out(f_second);
    assign r2 = round_out(f_third);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done <= 1'b0;
        else
            done <= ve_reg[NC-1];
    end
    always_ff @(posedge clk)
    begin
        if (ve_reg[NC-1])
        begin
            angle_first  <= r0;
            angle_second <= r1;
            angle_third  <= r2[14:0];
            case_kind    <= ke_reg[NC-1];
        end
    end

    // The CORDIC magnitude output of the asin bank is not needed.
    logic unused_ok;
    assign unused_ok = ^{ox2, ox[0], ox[1], ox[2]};

    // ---------------- assertions ----------------
    a_done_follows_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ve_reg[NC-1] |=> done)
        else $error("result strobe lost");

    a_zero_case: assert property (@(posedge clk) disable iff (!rst_n)
        done && case_kind == q2e_pkg::KIND_ZERO |-> angle_first == '0 && angle_second == '0)
        else $error("zero quaternion gave nonzero angles");

    a_pole_first: assert property (@(posedge clk) disable iff (!rst_n)
        done && (case_kind == q2e_pkg::KIND_NORTH || case_kind == q2e_pkg::KIND_SOUTH)
        |-> angle_first == '0)
        else $error("pole case gave nonzero first angle");

endmodule
`default_nettype wire

FILE: src/q2e_cordic.sv
// Pipelined CORDIC vectoring unit: one register stage per rotation step.
// Depends on q2e_pkg for the angle table and word types.
`default_nettype none
module q2e_cordic
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    input  q2e_pkg::cword_t      in_x,
    input  q2e_pkg::cword_t      in_y,
    input  q2e_pkg::angle_t      in_z,
    output q2e_pkg::cword_t      out_x,
    output q2e_pkg::angle_t      out_z
);

    localparam int N = q2e_pkg::CordicSteps;

    // Register stage i holds the vector after i rotations.
    q2e_pkg::cword_t x_reg [1:N];
    q2e_pkg::cword_t y_reg [1:N];
    q2e_pkg::angle_t z_reg [1:N];
    logic [N:1]      v_reg;

    q2e_pkg::cword_t x_cur  [0:N-1];
    q2e_pkg::cword_t y_cur  [0:N-1];
    q2e_pkg::angle_t z_cur  [0:N-1];
    logic [N-1:0]    v_cur;
    q2e_pkg::cword_t x_next [0:N-1];
    q2e_pkg::cword_t y_next [0:N-1];
    q2e_pkg::angle_t z_next [0:N-1];

    always_comb
    begin
        x_cur[0] = in_x;
        y_cur[0] = in_y;
        z_cur[0] = in_z;
        v_cur[0] = in_valid;
        for (int i = 1; i < N; i++)
        begin
            x_cur[i] = x_reg[i];
            y_cur[i] = y_reg[i];
            z_cur[i] = z_reg[i];
            v_cur[i] = v_reg[i];
        end
        for (int i = 0; i < N; i++)
        begin
            if (y_cur[i] > 0)
            begin
                x_next[i] = x_cur[i] + (y_cur[i] >>> i);
                y_next[i] = y_cur[i] - (x_cur[i] >>> i);
                z_next[i] = z_cur[i] + q2e_pkg::atan_entry(unsigned'(i));
            end
            else
            begin
                x_next[i] = x_cur[i] - (y_cur[i] >>> i);
                y_next[i] = y_cur[i] + (x_cur[i] >>> i);
                z_next[i] = z_cur[i] - q2e_pkg::atan_entry(unsigned'(i));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_cur;
    end

    // Payload is only advanced when it is carrying a word.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < N; i++)
        begin
            if (v_cur[i])
            begin
                x_reg[i+1] <= x_next[i];
                y_reg[i+1] <= y_next[i];
                z_reg[i+1] <= z_next[i];
            end
        end
    end

    assign out_x = x_reg[N];
    assign out_z = z_reg[N];

endmodule
`default_nettype wire
